/* design/ptw_pkg.sv */
// Package for the packet timing wheel: sizes, status codes, register indexes.
// No dependencies.
package ptw_pkg;
    localparam int NumQueues      = 4;
    localparam int WheelSlots     = 256;
    localparam int PacketsPerSlot = 16;

    localparam int CfgIdxW = 1;
    localparam logic [CfgIdxW-1:0] CFG_MAX_DELAY   = 1'd0;
    localparam logic [CfgIdxW-1:0] CFG_SLOT_PERIOD = 1'd1;

    localparam logic [23:0] MaxDelayReset   = 24'd1000000;
    localparam logic [15:0] SlotPeriodReset = 16'd1000;

    typedef enum logic [2:0] {
        ST_ACCEPTED  = 3'd0,
        ST_TOO_LARGE = 3'd1,
        ST_FULL      = 3'd2,
        ST_RELEASED  = 3'd3,
        ST_EMPTY     = 3'd4
    } t_status;
endpackage

/* design/ptw_ram.sv */
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module ptw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* design/ptw_div.sv */
// Restoring divider, one quotient bit per cycle: 24-bit dividend / 16-bit divisor.
// No dependencies.
module ptw_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [23:0] i_dividend,
    input  logic [15:0] i_divisor,
    output logic        o_done,
    output logic [23:0] o_quot
);
    logic [23:0] r_quot, n_quot;
    logic [16:0] r_rem, n_rem;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic [15:0] r_div;
    logic [17:0] w_trial;

    assign w_trial = {r_rem, r_quot[23]} - {2'b0, r_div};
    always_comb begin
        n_quot = {r_quot[22:0], 1'b0};
        n_rem  = {r_rem[15:0], r_quot[23]};
        if (!w_trial[17]) begin
            n_rem     = w_trial[16:0];
            n_quot[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd23;
                r_quot <= i_dividend;
                r_rem  <= '0;
                r_div  <= (i_divisor == 16'd0) ? 16'd1 : i_divisor;
            end else if (r_busy) begin
                r_quot <= n_quot;
                r_rem  <= n_rem;
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 5'd1;
                end
            end
        end
    end
    assign o_quot = r_quot;
endmodule

/* design/packet_timing_wheel_unit.sv */
// Packet timing wheel top level: sequencer, fill-count clear, slot stores.
// Depends on ptw_pkg, ptw_div, ptw_ram.
//
// Channel  Direction  Contents
// s_axis   in         tuser=kind; tdata={length,packet_handle,delay_us,wheel}
// m_axis   out        tuser=status; tdata={out_length,out_handle}; tlast=last
// cfg      in         index, 24-bit data
//
// Enqueue: serial divide, divider done, fill read, fill update and output;
// straight to output when the delay is at or above the maximum.
// Tick: pointer advance with fill read, fill check and output for an empty slot,
// else entry read and output per released packet. After reset a clearing pass
// zeroes all NUM_QUEUES*WHEEL_SLOTS fill counts while s_axis_tready stays low.
// Output holds in a register until taken; m_axis_tready low stalls the sequencer.
module packet_timing_wheel_unit #(
    parameter int NUM_QUEUES       = ptw_pkg::NumQueues,
    parameter int WHEEL_SLOTS      = ptw_pkg::WheelSlots,
    parameter int PACKETS_PER_SLOT = ptw_pkg::PacketsPerSlot
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // wheel[1:0], delay_us[25:2], handle[41:26], length[57:42]
    input  logic        s_axis_tuser,  // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // out_handle[15:0], out_length[31:16]
    output logic [2:0]  m_axis_tuser,  // status
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [ptw_pkg::CfgIdxW-1:0] i_cfg_index,
    input  logic [23:0] i_cfg_data
);
    import ptw_pkg::*;

    localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int SW = $clog2(WHEEL_SLOTS);
    localparam int PW = (PACKETS_PER_SLOT > 1) ? $clog2(PACKETS_PER_SLOT) : 1;
    localparam int FW = $clog2(PACKETS_PER_SLOT + 1);
    localparam int NSLOT = NUM_QUEUES * WHEEL_SLOTS;
    localparam int BW = $clog2(NSLOT);
    localparam int EW = $clog2(NSLOT * PACKETS_PER_SLOT);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DIV, S_FRD, S_FCHK, S_TRD, S_TCHK, S_ERD, S_EOUT, S_OUT
    } t_state;

    t_state      r_state;
    logic [23:0] r_max_delay;
    logic [15:0] r_period;
    logic [BW-1:0] r_clr;
    logic [QW-1:0] r_q;
    logic [15:0] r_handle, r_len;
    logic [SW-1:0] r_ptr [NUM_QUEUES];
    logic [BW-1:0] r_base;
    logic [FW-1:0] r_fill;

    logic [4:0]    w_qmod;
    logic [QW-1:0] w_q;
    logic          w_div_start, w_div_done;
    logic [23:0]   w_quot;
    logic          w_f_we;
    logic [BW-1:0] w_f_waddr, w_f_raddr;
    logic [FW-1:0] w_f_wdata, w_f_rdata;
    logic          w_e_we;
    logic [EW-1:0] w_e_waddr, w_e_raddr;
    logic [31:0]   w_e_rdata;
    logic [SW:0]   w_idx;
    logic [SW-1:0] w_slot;

    always_comb begin
        w_qmod = {3'b0, s_axis_tdata[1:0]};
        for (int k = 0; k < 3; k++) begin
            if (w_qmod >= 5'(NUM_QUEUES)) w_qmod = w_qmod - 5'(NUM_QUEUES);
        end
    end
    assign w_q = QW'(w_qmod);
    assign o_cfg_ready = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_delay <= MaxDelayReset;
            r_period    <= SlotPeriodReset;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MAX_DELAY:   r_max_delay <= i_cfg_data;
                CFG_SLOT_PERIOD: r_period    <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign w_div_start = (r_state == S_IDLE) && s_axis_tvalid && !s_axis_tuser
                         && (s_axis_tdata[25:2] < r_max_delay);

    ptw_div u_div (
        .i_clk, .i_rst_n, .i_start(w_div_start), .i_dividend(s_axis_tdata[25:2]),
        .i_divisor(r_period), .o_done(w_div_done), .o_quot(w_quot)
    );

    assign w_idx  = {1'b0, r_ptr[r_q]} + (SW+1)'(w_quot[SW-1:0]);
    assign w_slot = (w_idx >= (SW+1)'(WHEEL_SLOTS)) ? SW'(w_idx - (SW+1)'(WHEEL_SLOTS))
                                                    : w_idx[SW-1:0];

    always_comb begin
        w_f_raddr = r_base;
        if (r_state == S_DIV) begin
            w_f_raddr = BW'(r_q * WHEEL_SLOTS) + BW'(w_slot);
        end
    end

    assign w_f_we    = (r_state == S_CLEAR) || (r_state == S_FCHK && w_f_rdata < FW'(PACKETS_PER_SLOT))
                       || (r_state == S_TCHK);
    assign w_f_waddr = (r_state == S_CLEAR) ? r_clr : r_base;
    assign w_f_wdata = (r_state == S_FCHK) ? w_f_rdata + FW'(1) : '0;

    assign w_e_we    = (r_state == S_FCHK) && (w_f_rdata < FW'(PACKETS_PER_SLOT));
    assign w_e_waddr = EW'(r_base * PACKETS_PER_SLOT) + EW'(w_f_rdata[PW-1:0]);
    assign w_e_raddr = EW'(r_base * PACKETS_PER_SLOT) + EW'(r_fill[PW-1:0]);

    ptw_ram #(.WIDTH(FW), .DEPTH(NSLOT)) u_fill (
        .i_clk, .i_we(w_f_we), .i_waddr(w_f_waddr), .i_wdata(w_f_wdata),
        .i_raddr(w_f_raddr), .o_rdata(w_f_rdata)
    );
    ptw_ram #(.WIDTH(32), .DEPTH(NSLOT * PACKETS_PER_SLOT)) u_ent (
        .i_clk, .i_we(w_e_we), .i_waddr(w_e_waddr), .i_wdata({r_handle, r_len}),
        .i_raddr(w_e_raddr), .o_rdata(w_e_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            for (int i = 0; i < NUM_QUEUES; i++) r_ptr[i] <= '0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + BW'(1);
                    if (r_clr == BW'(NSLOT - 1)) r_state <= S_IDLE;
                end
                S_IDLE: if (s_axis_tvalid) begin
                    r_q      <= w_q;
                    r_handle <= s_axis_tdata[41:26];
                    r_len    <= s_axis_tdata[57:42];
                    m_axis_tdata <= '0;
                    m_axis_tlast <= 1'b1;
                    r_base   <= BW'(w_q * WHEEL_SLOTS) + BW'(r_ptr[w_q]);
                    if (s_axis_tuser) r_state <= S_TRD;
                    else if (w_div_start) r_state <= S_DIV;
                    else begin
                        m_axis_tuser <= ST_TOO_LARGE;
                        r_state <= S_OUT;
                    end
                end
                S_DIV: if (w_div_done) begin
                    r_base <= w_f_raddr;
                    if (w_quot >= 24'(WHEEL_SLOTS)) begin
                        m_axis_tuser <= ST_TOO_LARGE;
                        r_state <= S_OUT;
                    end else r_state <= S_FRD;
                end
                S_FRD: r_state <= S_FCHK;
                S_FCHK: begin
                    m_axis_tuser <= (w_f_rdata < FW'(PACKETS_PER_SLOT)) ? ST_ACCEPTED : ST_FULL;
                    r_state <= S_OUT;
                end
                S_TRD: begin
                    r_ptr[r_q] <= (r_ptr[r_q] == SW'(WHEEL_SLOTS - 1)) ? '0 : r_ptr[r_q] + SW'(1);
                    r_state <= S_TCHK;
                end
                S_TCHK: begin
                    if (w_f_rdata == '0) begin
                        m_axis_tuser <= ST_EMPTY;
                        r_state <= S_OUT;
                    end else begin
                        r_fill  <= w_f_rdata - FW'(1);
                        r_state <= S_ERD;
                    end
                end
                S_ERD: begin
                    r_state <= S_EOUT;
                end
                S_EOUT: begin
                    m_axis_tuser <= ST_RELEASED;
                    m_axis_tdata <= {w_e_rdata[15:0], w_e_rdata[31:16]};
                    m_axis_tlast <= (r_fill == '0);
                    r_state <= S_OUT;
                end
                S_OUT: if (m_axis_tready) begin
                    if (m_axis_tuser == ST_RELEASED && !m_axis_tlast) begin
                        r_fill  <= r_fill - FW'(1);
                        r_state <= S_ERD;
                    end else r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

/* tb/packet_timing_wheel_unit_test.sv */
// Self-checking bench for packet_timing_wheel_unit: directed table plus random traffic,
// every result checked against an in-bench wheel predictor. Depends on ptw_pkg.
module packet_timing_wheel_unit_test;
    import ptw_pkg::*;

    typedef struct packed {
        t_status     status;
        logic [15:0] handle;
        logic [15:0] length;
        logic        last;
    } t_release;

    typedef struct {
        logic        kind;
        logic [1:0]  queue;
        logic [23:0] delay;
        logic [15:0] handle;
        logic [15:0] length;
        logic        check_first;
        t_status     first_status;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [CfgIdxW-1:0] i_cfg_index = '0;
    logic [23:0] i_cfg_data = '0;

    packet_timing_wheel_unit dut (.*);

    always #4 i_clk = ~i_clk;

    // predictor state
    logic [23:0] max_delay;
    logic [15:0] slot_period;
    logic [7:0]  wheel_ptr [NumQueues];
    int          slot_count [NumQueues*WheelSlots];
    logic [31:0] slot_store [NumQueues*WheelSlots*PacketsPerSlot];

    t_release expected_q [$];
    int  mismatches = 0;
    int  idle_cycles = 0;
    int  send_idle_pct = 7;
    int  recv_idle_pct = 61;
    t_row rows [$];

    // predictor: returns first expected status
    function automatic t_status predict_wheel(input t_row r);
        int q, slot, base, off, fill;
        logic [15:0] per;
        q = r.queue % NumQueues;
        if (!r.kind) begin
            per = (slot_period == 0) ? 16'd1 : slot_period;
            if (r.delay >= max_delay || r.delay / per >= WheelSlots) begin
                expected_q.push_back('{ST_TOO_LARGE, 16'd0, 16'd0, 1'b1});
                return ST_TOO_LARGE;
            end
            off = r.delay / per;
            slot = (wheel_ptr[q] + off) % WheelSlots;
            base = q * WheelSlots + slot;
            if (slot_count[base] >= PacketsPerSlot) begin
                expected_q.push_back('{ST_FULL, 16'd0, 16'd0, 1'b1});
                return ST_FULL;
            end
            slot_store[base*PacketsPerSlot + slot_count[base]] = {r.handle, r.length};
            slot_count[base]++;
            expected_q.push_back('{ST_ACCEPTED, 16'd0, 16'd0, 1'b1});
            return ST_ACCEPTED;
        end
        base = q * WheelSlots + wheel_ptr[q];
        wheel_ptr[q] = wheel_ptr[q] + 8'd1;
        fill = slot_count[base];
        if (fill == 0) begin
            expected_q.push_back('{ST_EMPTY, 16'd0, 16'd0, 1'b1});
            return ST_EMPTY;
        end
        while (fill > 0) begin
            fill--;
            expected_q.push_back('{ST_RELEASED, slot_store[base*PacketsPerSlot+fill][31:16],
                                   slot_store[base*PacketsPerSlot+fill][15:0], fill == 0});
        end
        slot_count[base] = 0;
        return ST_RELEASED;
    endfunction

    task automatic note_mismatch(input t_release exp_r, input t_release act_r);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch: expected st=%0d h=%h l=%h last=%b, got st=%0d h=%h l=%h last=%b",
                     exp_r.status, exp_r.handle, exp_r.length, exp_r.last,
                     act_r.status, act_r.handle, act_r.length, act_r.last);
    endtask

    // output checker, receiver stall and watchdog
    always @(posedge i_clk) begin
        t_release act_r, exp_r;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                act_r = '{t_status'(m_axis_tuser), m_axis_tdata[15:0], m_axis_tdata[31:16],
                          m_axis_tlast};
                if (expected_q.size() == 0) begin
                    exp_r = '0;
                    note_mismatch(exp_r, act_r);
                end else begin
                    exp_r = expected_q.pop_front();
                    if (act_r != exp_r) note_mismatch(exp_r, act_r);
                end
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                    || (i_cfg_valid && o_cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (idle_cycles > 20000) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_item(input t_row r);
        t_status first;
        while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= r.kind;
        s_axis_tdata  <= {6'd0, r.length, r.handle, r.delay, r.queue};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        first = predict_wheel(r);
        if (r.check_first && first != r.first_status) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: table expects st=%0d, predictor gives %0d",
                         r.first_status, first);
        end
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain_results();
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [23:0] value);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_MAX_DELAY) max_delay = value;
        else slot_period = value[15:0];
    endtask

    function automatic t_row mk(input logic kind, input logic [1:0] q, input logic [23:0] d,
                                input logic [15:0] h, input logic [15:0] l,
                                input logic chk, input t_status st);
        t_row r;
        r = '{kind, q, d, h, l, chk, st};
        return r;
    endfunction

    function automatic t_row rand_enq(input int qmax, input int dmax);
        return mk(1'b0, 2'($urandom_range(qmax)), 24'($urandom_range(dmax)),
                  16'($urandom), 16'($urandom), 1'b0, ST_ACCEPTED);
    endfunction

    function automatic t_row rand_tick(input int qmax);
        return mk(1'b1, 2'($urandom_range(qmax)), 24'($urandom), 16'($urandom),
                  16'($urandom), 1'b0, ST_EMPTY);
    endfunction

    task automatic random_phase(input int count, input int qmax);
        repeat (count) begin
            if ($urandom_range(99) < 60) send_item(rand_enq(qmax, 4000));
            else if ($urandom_range(99) < 10) send_item(rand_enq(3, 24'hFFFFFF));
            else send_item(rand_tick(qmax));
        end
    endtask

    initial begin
        max_delay = MaxDelayReset;
        slot_period = SlotPeriodReset;
        foreach (wheel_ptr[i]) wheel_ptr[i] = '0;
        foreach (slot_count[i]) slot_count[i] = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        rows.push_back(mk(1'b1, 2'd0, 24'd0, 16'd0, 16'd0, 1'b1, ST_EMPTY));
        rows.push_back(mk(1'b0, 2'd0, 24'hFFFFFF, 16'hFFFF, 16'hFFFF, 1'b1, ST_TOO_LARGE));
        rows.push_back(mk(1'b0, 2'd0, 24'd999999, 16'd0, 16'd0, 1'b1, ST_TOO_LARGE));
        rows.push_back(mk(1'b0, 2'd1, 24'd0, 16'hFFFF, 16'h0000, 1'b1, ST_ACCEPTED));
        rows.push_back(mk(1'b0, 2'd1, 24'd999, 16'h0000, 16'hFFFF, 1'b1, ST_ACCEPTED));
        rows.push_back(mk(1'b0, 2'd3, 24'd255999, 16'hA5A5, 16'h5A5A, 1'b1, ST_ACCEPTED));
        rows.push_back(mk(1'b0, 2'd3, 24'd256000, 16'h1234, 16'h4321, 1'b1, ST_TOO_LARGE));
        rows.push_back(mk(1'b1, 2'd1, 24'd0, 16'd0, 16'd0, 1'b1, ST_RELEASED));
        rows.push_back(mk(1'b1, 2'd2, 24'hFFFFFF, 16'hFFFF, 16'hFFFF, 1'b1, ST_EMPTY));
        for (int i = 0; i < 17; i++)
            rows.push_back(mk(1'b0, 2'd2, 24'd1500, 16'(16'h100 + i), 16'(16'h200 + i), 1'b1,
                              t_status'((i < 16) ? ST_ACCEPTED : ST_FULL)));
        rows.push_back(mk(1'b1, 2'd2, 24'd0, 16'd0, 16'd0, 1'b1, ST_EMPTY));
        rows.push_back(mk(1'b1, 2'd2, 24'd0, 16'd0, 16'd0, 1'b1, ST_RELEASED));
        foreach (rows[i]) send_item(rows[i]);

        // zero period, then twenty enqueues on queue 0 and a drain
        write_reg(CFG_SLOT_PERIOD, 24'd0);
        for (int i = 0; i < 20; i++)
            send_item(mk(1'b0, 2'd0, 24'(i * 13), 16'($urandom), 16'($urandom), 1'b0,
                         ST_ACCEPTED));
        drain_results();
        write_reg(CFG_MAX_DELAY, 24'd0);
        send_item(mk(1'b0, 2'd1, 24'd0, 16'd1, 16'd1, 1'b1, ST_TOO_LARGE));
        write_reg(CFG_MAX_DELAY, 24'hFFFFFF);
        write_reg(CFG_SLOT_PERIOD, 24'hFFFFFF);

        send_idle_pct = 7;  recv_idle_pct = 61;
        random_phase(20, 3);
        write_reg(CFG_SLOT_PERIOD, 24'd1);
        write_reg(CFG_MAX_DELAY, 24'd1);
        send_idle_pct = 61; recv_idle_pct = 7;
        random_phase(5, 3);
        write_reg(CFG_MAX_DELAY, 24'd3000);
        write_reg(CFG_SLOT_PERIOD, 24'd500);
        random_phase(15, 1);
        send_idle_pct = 0;  recv_idle_pct = 0;
        write_reg(CFG_SLOT_PERIOD, 24'd1000);
        write_reg(CFG_MAX_DELAY, 24'd1);
        write_reg(CFG_MAX_DELAY, 24'd1000000);
        random_phase(15, 3);

        drain_results();
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

/* filelist.f */
design/ptw_pkg.sv
design/ptw_ram.sv
design/ptw_div.sv
design/packet_timing_wheel_unit.sv
tb/packet_timing_wheel_unit_test.sv
